>>> rtl/lgmc_pkg.sv
// Package for the lazy Gram-matrix entry cache: sizes, payload structs, codes.
// No dependencies.
package lgmc_pkg;

   localparam int MaxRows = 256;
   localparam int MaxCols = 64;
   localparam int RowW = $clog2(MaxRows);
   localparam int ColW = $clog2(MaxCols);
   localparam int SampleDepth = MaxRows * MaxCols;
   localparam int SlotDepth = MaxCols * MaxCols;
   localparam int SampleAw = $clog2(SampleDepth);
   localparam int SlotAw = $clog2(SlotDepth);
   localparam int ProdW = 40;

   localparam logic [1:0] CsrRowCount = 2'd0;
   localparam logic [1:0] CsrColCount = 2'd1;
   localparam logic [1:0] CsrDenseMode = 2'd2;

   typedef enum logic [1:0] {
      ACT_WRITE_SAMPLE = 2'd0,
      ACT_WRITE_ENTRY  = 2'd1,
      ACT_QUERY_PAIR   = 2'd2,
      ACT_QUERY_LINEAR = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [11:0]        index_a;
      logic [7:0]         index_b;
      logic signed [15:0] sample;
      logic signed [39:0] entry_value;
   } req_type;

   typedef struct packed {
      logic signed [39:0] product;
      logic               was_cached;
      logic               index_error;
   } rsp_type;

endpackage

>>> rtl/lazy_gram_matrix_entry_cache.sv
// Lazy Gram-matrix entry cache: sample memory, product table, computed flags.
// Request to result: an index error is answered from idle; a pair hit passes look and
// decide; a linear query first splits its index by subtraction; a lazy miss runs the
// rows in use and drains. Writes take effect when accepted. One item at a time; a miss
// reads two samples per row, one multiply-accumulate per row. Reset (synchronous, active
// high) clears the computed flags before the first transfer. Depends on lgmc_pkg.
module lazy_gram_matrix_entry_cache import lgmc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [8:0] csr_data
);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_SPLIT = 8'b0000_0100,
      ST_LOOK  = 8'b0000_1000,
      ST_DECIDE= 8'b0001_0000,
      ST_MAC   = 8'b0010_0000,
      ST_DRAIN = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   logic [ProdW-1:0] prod_mem [SlotDepth];
   logic             flag_mem [SlotDepth];
   logic [15:0]      samp_mem [SampleDepth];

   state_type state_ff, state_in;
   logic [8:0] row_count_ff;
   logic [6:0] col_count_ff;
   logic       dense_ff;
   logic [SlotAw:0] clr_ff, clr_in;
   logic [ColW-1:0] a_ff, a_in, b_ff, b_in;
   logic [11:0] k_ff, k_in;
   logic [8:0]  row_ff, row_in;
   logic        phase_ff, phase_in;
   logic [15:0] x_ff, x_in;
   logic signed [31:0] mul_ff, mul_in;
   logic        mulv_ff, mulv_in;
   logic [ProdW-1:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [ProdW-1:0] prod_rd;
   logic             flag_rd;
   logic [15:0]      samp_rd;
   logic             samp_rd_v_ff;
   logic             samp_x_ff;

   logic [6:0] cc;
   logic [8:0] rn;
   logic [SlotAw-1:0] slot;
   logic [12:0] cc_sq;
   logic        rsp_free;
   logic        p_we, f_we, f_val, s_we;
   logic [SlotAw-1:0] p_wa, f_wa;
   logic [ProdW-1:0]  p_wd;
   logic [SampleAw-1:0] s_addr;
   logic        s_re, s_is_x;

   assign cc = (col_count_ff > 7'(MaxCols)) ? 7'(MaxCols) : col_count_ff;
   assign rn = (row_count_ff > 9'(MaxRows)) ? 9'(MaxRows) : row_count_ff;
   assign cc_sq = 13'(cc) * 13'(cc);
   assign slot = {a_ff, b_ff};
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && rsp_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 9'(MaxRows);
         col_count_ff <= 7'(MaxCols);
         dense_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrRowCount:  row_count_ff <= csr_data;
            CsrColCount:  col_count_ff <= csr_data[6:0];
            CsrDenseMode: dense_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (p_we) prod_mem[p_wa] <= p_wd;
      prod_rd <= prod_mem[slot];
   end
   always_ff @(posedge clock) begin
      if (f_we) flag_mem[f_wa] <= f_val;
      flag_rd <= flag_mem[slot];
   end
   always_ff @(posedge clock) begin
      if (s_we) samp_mem[s_addr] <= req_data.sample;
      if (s_re) samp_rd <= samp_mem[s_addr];
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      row_in = row_ff;
      phase_in = phase_ff;
      x_in = x_ff;
      mul_in = mul_ff;
      mulv_in = 1'b0;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      p_we = 1'b0; p_wa = slot; p_wd = acc_ff;
      f_we = 1'b0; f_wa = slot; f_val = 1'b1;
      s_we = 1'b0; s_re = 1'b0; s_is_x = 1'b0;
      s_addr = SampleAw'({b_ff, row_ff[RowW-1:0]});
      if (samp_rd_v_ff) begin
         if (samp_x_ff) x_in = samp_rd;
         else begin
            mul_in = $signed(x_ff) * $signed(samp_rd);
            mulv_in = 1'b1;
         end
      end
      if (mulv_ff) acc_in = acc_ff + ProdW'(mul_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            f_we = 1'b1; f_wa = clr_ff[SlotAw-1:0]; f_val = 1'b0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SlotAw+1)'(SlotDepth - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (action_type'(req_data.action))
                  ACT_WRITE_SAMPLE: begin
                     s_addr = SampleAw'({req_data.index_b[ColW-1:0],
                                         req_data.index_a[RowW-1:0]});
                     s_we = (req_data.index_a < 12'(MaxRows)) &&
                            (req_data.index_b < 8'(MaxCols));
                  end
                  ACT_WRITE_ENTRY: begin
                     p_wa = {req_data.index_a[ColW-1:0], req_data.index_b[ColW-1:0]};
                     p_wd = req_data.entry_value;
                     p_we = (req_data.index_a < 12'(MaxCols)) &&
                            (req_data.index_b < 8'(MaxCols));
                  end
                  ACT_QUERY_PAIR: begin
                     a_in = req_data.index_a[ColW-1:0];
                     b_in = req_data.index_b[ColW-1:0];
                     if (req_data.index_a >= 12'(cc) || req_data.index_b >= 8'(cc)) begin
                        rsp_in = '{product: '0, was_cached: 1'b0, index_error: 1'b1};
                        rsp_valid_in = 1'b1;
                     end else state_in = ST_LOOK;
                  end
                  default: begin
                     if (cc == 7'd0 || 13'(req_data.index_a) >= cc_sq) begin
                        rsp_in = '{product: '0, was_cached: 1'b0, index_error: 1'b1};
                        rsp_valid_in = 1'b1;
                     end else begin
                        k_in = req_data.index_a;
                        b_in = '0;
                        state_in = ST_SPLIT;
                     end
                  end
               endcase
            end
         end
         ST_SPLIT: begin
            // repeated subtraction, one column per cycle
            if (k_ff >= 12'(cc)) begin
               k_in = k_ff - 12'(cc);
               b_in = b_ff + 1'b1;
            end else begin
               a_in = k_ff[ColW-1:0];
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (dense_ff || flag_rd) begin
               if (rsp_free) begin
                  rsp_in = '{product: prod_rd, was_cached: 1'b1, index_error: 1'b0};
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               acc_in = '0;
               row_in = '0;
               phase_in = 1'b0;
               state_in = (rn == 9'd0) ? ST_DRAIN : ST_MAC;
            end
         end
         ST_MAC: begin
            s_re = 1'b1;
            s_is_x = !phase_ff;
            s_addr = SampleAw'({phase_ff ? b_ff : a_ff, row_ff[RowW-1:0]});
            phase_in = !phase_ff;
            if (phase_ff) begin
               row_in = row_ff + 1'b1;
               if (row_ff + 1'b1 == rn) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!samp_rd_v_ff && !mulv_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               p_we = 1'b1; p_wd = acc_ff;
               f_we = 1'b1; f_val = 1'b1;
               rsp_in = '{product: acc_ff, was_cached: 1'b0, index_error: 1'b0};
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         samp_rd_v_ff <= 1'b0;
         mulv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         samp_rd_v_ff <= s_re;
         mulv_ff <= mulv_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
      row_ff <= row_in;
      phase_ff <= phase_in;
      x_ff <= x_in;
      mul_ff <= mul_in;
      acc_ff <= acc_in;
      rsp_ff <= rsp_in;
      samp_x_ff <= s_is_x;
   end

   ap_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accept while busy");
   ap_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.index_error) |-> (rsp_data.product == '0 &&
      !rsp_data.was_cached)) else $error("error result not zero");
   ap_done_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("miss lost result");

endmodule
